// ===== hdl/lfsr42_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr42_pkg
// Shared types and constants for the 42-bit LFSR jump-ahead pipeline,
// including the elaboration-time column tables of the jump matrices.
// ----------------------------------------------------------------------------
package lfsr42_pkg;

   localparam int LFSR_BITS = 42;

   typedef logic [LFSR_BITS-1:0] vec_type;
   typedef logic [LFSR_BITS-1:0][LFSR_BITS-1:0] mat_type;
   typedef logic [LFSR_BITS-1:0][LFSR_BITS-1:0][LFSR_BITS-1:0] mat_set_type;

   // fixed offset added to every requested count
   localparam vec_type JUMP_BIAS = vec_type'(41);
   // state the register starts from before the jump
   localparam vec_type START_STATE = vec_type'(1);
   // feedback taps below x^42
   localparam vec_type TAP_MASK = 42'h0A8_E6F0_4EF;

   // control and data travelling down the pipeline
   typedef struct packed {
      logic    vld;
      vec_type ex;
      vec_type vec;
   } stage_type;

   // one register step: multiply by x modulo the feedback polynomial
   function automatic vec_type lfsr_advance(vec_type v);
      vec_type r;
      r = {v[LFSR_BITS-2:0], 1'b0};
      if (v[LFSR_BITS-1]) begin
         r = r ^ TAP_MASK;
      end
      return r;
   endfunction

   // product of two residues, used only to build constant tables
   function automatic vec_type poly_mul(vec_type a, vec_type b);
      vec_type acc;
      acc = '0;
      for (int i = LFSR_BITS - 1; i >= 0; i--) begin
         acc = lfsr_advance(acc);
         if (b[i]) begin
            acc = acc ^ a;
         end
      end
      return acc;
   endfunction

   // column j of stage k is x^(2^k + j) mod P
   function automatic mat_set_type build_cols();
      mat_set_type m;
      vec_type     base;
      vec_type     col;
      m    = '0;
      base = vec_type'(2);
      for (int k = 0; k < LFSR_BITS; k++) begin
         col = base;
         for (int j = 0; j < LFSR_BITS; j++) begin
            m[k][j] = col;
            col     = lfsr_advance(col);
         end
         base = poly_mul(base, base);
      end
      return m;
   endfunction

   localparam mat_set_type JUMP_COLS = build_cols();

endpackage

// ===== hdl/lfsr42_bias.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr42_bias
// Entry stage: registers the biased jump exponent and seeds the state.
// ----------------------------------------------------------------------------
module lfsr42_bias (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  lfsr42_pkg::vec_type  jump_count,
   output lfsr42_pkg::stage_type stage_out
);

   logic                vld_ff;
   logic                vld_in;
   lfsr42_pkg::vec_type ex_ff;
   lfsr42_pkg::vec_type ex_in;

   // exponent wraps modulo 2^42
   always_comb begin
      vld_in = take;
      ex_in  = jump_count + lfsr42_pkg::JUMP_BIAS;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ex_ff <= ex_in;
   end

   assign stage_out.vld = vld_ff;
   assign stage_out.ex  = ex_ff;
   assign stage_out.vec = lfsr42_pkg::START_STATE;

endmodule

// ===== hdl/lfsr42_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr42_chain
// One register stage per exponent bit; stage k multiplies the state by
// x^(2^k) mod P when bit k is set, as a constant GF(2) matrix.
// ----------------------------------------------------------------------------
module lfsr42_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  lfsr42_pkg::stage_type stage_in,
   output lfsr42_pkg::stage_type stage_out
);

   localparam int N = lfsr42_pkg::LFSR_BITS;

   logic                vld_ff [N];
   logic                vld_in [N];
   lfsr42_pkg::vec_type ex_ff  [N];
   lfsr42_pkg::vec_type ex_in  [N];
   lfsr42_pkg::vec_type vec_ff [N];
   lfsr42_pkg::vec_type vec_in [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      lfsr42_pkg::stage_type src;
      lfsr42_pkg::vec_type   prod;

      // previous stage or pipeline entry
      if (k == 0) begin : g_first
         assign src = stage_in;
      end else begin : g_next
         assign src.vld = vld_ff[k-1];
         assign src.ex  = ex_ff[k-1];
         assign src.vec = vec_ff[k-1];
      end

      // constant matrix times state: xor of selected columns
      always_comb begin
         prod = '0;
         for (int j = 0; j < N; j++) begin
            if (src.vec[j]) begin
               prod = prod ^ lfsr42_pkg::JUMP_COLS[k][j];
            end
         end
         vld_in[k] = src.vld;
         ex_in[k]  = src.ex;
         vec_in[k] = src.ex[k] ? prod : src.vec;
      end

      // valid bit
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_in[k];
         end
      end

      // payload
      always_ff @(posedge clock) begin
         ex_ff[k]  <= ex_in[k];
         vec_ff[k] <= vec_in[k];
      end
   end

   assign stage_out.vld = vld_ff[N-1];
   assign stage_out.ex  = ex_ff[N-1];
   assign stage_out.vec = vec_ff[N-1];

endmodule

// ===== hdl/lfsr42_jump_ahead.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr42_jump_ahead
// Jump-ahead for the 42-bit Galois long-code LFSR: returns the state reached
// from state 1 after (req_jump_count + 41) mod 2^42 steps.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_jump_count and pulse start; a transfer happens at a
//   rising edge with start high and busy low. busy is never raised, so a
//   new request may be given in every cycle.
//   Response: rsp_valid is high for one cycle with rsp_lfsr_state; the
//   transfer completes at the edge ending that cycle.
//   Pipeline: the exponent bias register, then one register stage for each
//   of the 42 exponent bits, each bit stage being one constant 42x42 GF(2)
//   matrix multiply.
//   Throughput: one request per cycle, responses in request order.
//   Reset: synchronous; clears every valid bit, so requests in flight are
//   dropped and no response appears until new requests arrive.
//   The receiver cannot stall; responses are never held back.
// ----------------------------------------------------------------------------
module lfsr42_jump_ahead (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [41:0] req_jump_count,
   output logic        rsp_valid,
   output logic [41:0] rsp_lfsr_state
);

   lfsr42_pkg::stage_type entry_stage;
   lfsr42_pkg::stage_type last_stage;
   logic                  take;

   // the pipeline never stalls
   assign busy = 1'b0;
   assign take = start & ~busy;

   // exponent bias stage
   lfsr42_bias u_bias (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .jump_count (req_jump_count),
      .stage_out  (entry_stage)
   );

   // per-bit matrix stages
   lfsr42_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (entry_stage),
      .stage_out (last_stage)
   );

   // response straight from the last stage register
   assign rsp_valid      = last_stage.vld;
   assign rsp_lfsr_state = last_stage.vec;

endmodule

// ===== hdl/lfsr42_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr42_chk
// Port-level checker for the jump-ahead block, bound to the top level.
// ----------------------------------------------------------------------------
module lfsr42_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [41:0] req_jump_count,
   input logic        rsp_valid,
   input logic [41:0] rsp_lfsr_state
);

   // every request transfer yields a response
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##43 rsp_valid)
      else $error("response missing after request");

   // no response without a matching request
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 43))
      else $error("response without request");

   // wrap case: the biased count is zero, result is the start state
   a_wrap : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_jump_count == 42'h3FF_FFFF_FFD7)
      |-> ##43 (rsp_lfsr_state == 42'd1))
      else $error("wrap case does not return start state");

   // zero count: 41 steps from state 1 give only the top stage set
   a_zero : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_jump_count == 42'd0)
      |-> ##43 (rsp_lfsr_state == 42'h200_0000_0000))
      else $error("zero count gives wrong state");

endmodule

bind lfsr42_jump_ahead lfsr42_chk u_lfsr42_chk (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_jump_count (req_jump_count),
   .rsp_valid      (rsp_valid),
   .rsp_lfsr_state (rsp_lfsr_state)
);
